FILE: design/rhp_pkg.sv
// rhp_pkg: shared types, codes and field tables for the radiotap header parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rhp_pkg;

  localparam int FifoDepth = 4;
  localparam logic [4:0] NoField = 5'd31;

  typedef enum logic [3:0] {
    KIND_TSFT      = 4'd0,
    KIND_RXFLAGS   = 4'd1,
    KIND_RATE      = 4'd2,
    KIND_FREQ      = 4'd3,
    KIND_CHANFLAGS = 4'd4,
    KIND_SIGNAL    = 4'd5,
    KIND_TXFAIL    = 4'd6,
    KIND_RTS       = 4'd7,
    KIND_DATARETRY = 4'd8,
    KIND_PKTTIME   = 4'd9,
    KIND_END       = 4'd10
  } kind_t;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_BAD_VERSION = 3'd1,
    ERR_BAD_LENGTH  = 3'd2,
    ERR_OVERRUN     = 3'd3,
    ERR_SHORT_READ  = 3'd4,
    ERR_TURBO       = 3'd5
  } err_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_HDR    = 5'b00010,
    PH_BITMAP = 5'b00100,
    PH_FIELDS = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_of_frame;
    logic [15:0] frame_len;
  } in_t;

  typedef struct packed {
    logic [3:0]  field_kind;
    logic [63:0] field_value;
    logic [2:0]  error_code;
    logic        is_last;
  } out_t;

  typedef struct packed {
    logic [4:0]  fbit;        // NoField when nothing is pending
    logic        short_read;
    logic [15:0] start;
  } seek_t;

  // parts per present bit
  function automatic logic [3:0] part_count(input logic [4:0] idx);
    logic [3:0] c;
    case (idx)
      5'd3, 5'd4, 5'd7, 5'd8, 5'd9: c = 4'd2;
      5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27,
      5'd30, 5'd31: c = 4'd0;
      5'd28: c = 4'd15;
      default: c = 4'd1;
    endcase
    return c;
  endfunction

  // bytes per part, also the alignment
  function automatic logic [3:0] part_size(input logic [4:0] idx);
    logic [3:0] s;
    case (idx)
      5'd0: s = 4'd8;
      5'd3, 5'd14, 5'd15: s = 4'd2;
      5'd29: s = 4'd4;
      default: s = 4'd1;
    endcase
    return s;
  endfunction

endpackage

FILE: design/radiotap_header_parser_top.sv
// radiotap_header_parser_top: byte-stream radiotap header parser, core plus result queue.
// Depends on rhp_pkg, rhp_core, rhp_seek and rhp_fifo.
//
//   channel | dir | word      | handshake
//   in_     | in  | rhp in_t  | in_valid / in_stall
//   out_    | out | rhp out_t | out_valid / out_stall
//
// One byte per cycle while in_stall is low; each byte is decoded in the cycle it is taken.
// A byte yields zero, one or two words into a FifoDepth-entry queue.
// in_stall rises when fewer than two queue entries are free.
// rst_n is synchronous and clears parse state and the queue.
`timescale 1ns / 1ps

module radiotap_header_parser_top #(
  parameter int FifoDepth = rhp_pkg::FifoDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rhp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rhp_pkg::out_t out_data
);

  logic          room2, accept, r0_v, r1_v;
  rhp_pkg::out_t r0, r1;

  assign in_stall = !room2;
  assign accept   = in_valid && room2;

  rhp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .res0_v  (r0_v),
    .res0    (r0),
    .res1_v  (r1_v),
    .res1    (r1)
  );

  rhp_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (r0_v),
    .data0     (r0),
    .push1     (r1_v),
    .data1     (r1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: design/rhp_seek.sv
// rhp_seek: finds the next pending field part and aligns its start offset.
// Depends on rhp_pkg.
`timescale 1ns / 1ps

module rhp_seek (
  input  logic [31:0]    present,
  input  logic [4:0]     cur_bit,
  input  logic [3:0]     part_idx,
  input  logic [15:0]    field_start,
  input  logic [15:0]    hdr_len,
  output rhp_pkg::seek_t result
);

  logic [30:0] elig;
  logic [4:0]  fbit;
  logic [3:0]  size;
  logic [16:0] aligned;
  logic [17:0] span_end;

  always_comb begin
    for (int i = 0; i < 31; i++) begin
      elig[i] = present[i] && (rhp_pkg::part_count(5'(i)) != 4'd0) &&
                ((5'(i) > cur_bit) ||
                 ((5'(i) == cur_bit) && (part_idx < rhp_pkg::part_count(5'(i)))));
    end
    fbit = rhp_pkg::NoField;
    for (int i = 30; i >= 0; i--) begin
      if (elig[i]) fbit = 5'(i);
    end
  end

  assign size     = rhp_pkg::part_size(fbit);
  assign aligned  = ({1'b0, field_start} + {13'd0, size} - 17'd1) & ~({13'd0, size} - 17'd1);
  assign span_end = {1'b0, aligned} + {14'd0, size};

  assign result.fbit       = fbit;
  assign result.short_read = (fbit != rhp_pkg::NoField) && (span_end > {2'b00, hdr_len});
  assign result.start      = aligned[15:0];

endmodule

FILE: design/rhp_fifo.sv
// rhp_fifo: result queue taking up to two words a cycle, one word out while out_stall is low.
// Depends on rhp_pkg.
`timescale 1ns / 1ps

module rhp_fifo #(
  parameter int Depth = rhp_pkg::FifoDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push0,
  input  rhp_pkg::out_t data0,
  input  logic          push1,
  input  rhp_pkg::out_t data1,
  output logic          room2,
  output logic          out_valid,
  input  logic          out_stall,
  output rhp_pkg::out_t out_data
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  rhp_pkg::out_t mem [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;
  logic [1:0]    npush;
  logic [AW-1:0] wp1;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign pop       = out_valid && !out_stall;
  assign npush     = {1'b0, push0} + {1'b0, push1};
  assign wp1       = inc(wp_r);
  assign count_nxt = count_r + CW'(npush) - CW'(pop);
  assign room2     = count_r <= CW'(Depth - 2);
  assign out_valid = count_r != '0;
  assign out_data  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push0) mem[wp_r] <= data0;
    if (push1) mem[push0 ? wp1 : wp_r] <= data1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      case (npush)
        2'd1:    wp_r <= wp1;
        2'd2:    wp_r <= inc(wp1);
        default: wp_r <= wp_r;
      endcase
      if (pop) rp_r <= inc(rp_r);
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(npush) <= CW'(Depth) - count_r + CW'(pop))
    else $error("result queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(Depth))
    else $error("queue count out of range");
  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && npush == 2'd0) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("pop did not drain queue");

endmodule

FILE: design/rhp_core.sv
// rhp_core: per-byte parse state and decode; emits up to two result words per byte.
// Depends on rhp_pkg and rhp_seek.
`timescale 1ns / 1ps

module rhp_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  rhp_pkg::in_t  in_data,
  output logic          res0_v,
  output rhp_pkg::out_t res0,
  output logic          res1_v,
  output rhp_pkg::out_t res1
);

  rhp_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] off_r, off_nxt, hl_r, hl_nxt, fl_r, fl_nxt, fs_r, fs_nxt;
  logic [31:0] pres_r, pres_nxt;
  logic [4:0]  cur_r, cur_nxt;
  logic [3:0]  part_r, part_nxt, fbl_r, fbl_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [7:0]  cfb_r, cfb_nxt;
  logic        fcs_r, fcs_nxt;

  logic [7:0]  b;
  logic [15:0] o, o1, hl_new, w;
  logic [31:0] word, sk_pres;
  logic        run_after;
  logic [4:0]  sk_cur;
  logic [3:0]  sk_part, size, fbl_eff, kdiff;
  logic [63:0] acc_new;
  logic [7:0]  m;
  logic [17:0] pay;
  rhp_pkg::seek_t sk;

  rhp_seek u_seek (
    .present     (sk_pres),
    .cur_bit     (sk_cur),
    .part_idx    (sk_part),
    .field_start (o1),
    .hdr_len     (hl_r),
    .result      (sk)
  );

  assign b  = in_data.data_byte;
  assign o  = off_r + 16'd1;
  assign o1 = o + 16'd1;
  assign word = {b, acc_r[23:0]};

  // seek inputs come from registers and the input byte, never from the comb block, so the search never loops through it
  assign sk_pres = (phase_r == rhp_pkg::PH_BITMAP && o == 16'd7) ? word : pres_r;
  assign sk_cur  = (phase_r == rhp_pkg::PH_BITMAP) ? 5'd0 : cur_r;
  assign sk_part = (phase_r == rhp_pkg::PH_BITMAP) ? 4'd0 :
                   ((cur_r != rhp_pkg::NoField) ? part_r + 4'd1 : part_r);

  always_comb begin
    phase_nxt = phase_r; off_nxt = off_r; hl_nxt = hl_r; fl_nxt = fl_r;
    fs_nxt = fs_r; pres_nxt = pres_r; cur_nxt = cur_r; part_nxt = part_r;
    fbl_nxt = fbl_r; acc_nxt = acc_r; cfb_nxt = cfb_r; fcs_nxt = fcs_r;
    res0_v = 1'b0; res0 = '0; res1_v = 1'b0; res1 = '0;
    run_after = 1'b0;
    hl_new = {b, hl_r[7:0]};
    size = rhp_pkg::part_size(cur_r);
    fbl_eff = fbl_r; kdiff = '0; acc_new = acc_r; m = '0;
    w = acc_r[15:0];
    pay = '0;

    if (accept) begin
      if (in_data.start_of_frame) begin
        off_nxt = '0; hl_nxt = '0; fs_nxt = '0; pres_nxt = '0; cur_nxt = '0;
        part_nxt = '0; fbl_nxt = '0; acc_nxt = '0; cfb_nxt = '0; fcs_nxt = 1'b0;
        fl_nxt = in_data.frame_len;
        if (b != 8'd0) begin
          res1_v = 1'b1;
          res1 = '{rhp_pkg::KIND_END, 64'd0, rhp_pkg::ERR_BAD_VERSION, 1'b1};
          phase_nxt = rhp_pkg::PH_DONE;
        end else begin
          phase_nxt = rhp_pkg::PH_HDR;
        end
      end else if (phase_r != rhp_pkg::PH_IDLE && phase_r != rhp_pkg::PH_DONE) begin
        off_nxt = o;
        case (phase_r)
          rhp_pkg::PH_HDR: begin
            if (o == 16'd2) begin
              hl_nxt = {8'd0, b};
            end else if (o == 16'd3) begin
              hl_nxt = hl_new;
              if (hl_new < 16'd8 || hl_new > fl_r) begin
                res1_v = 1'b1;
                res1 = '{rhp_pkg::KIND_END, 64'd0, rhp_pkg::ERR_BAD_LENGTH, 1'b1};
                phase_nxt = rhp_pkg::PH_DONE;
              end else begin
                phase_nxt = rhp_pkg::PH_BITMAP;
                acc_nxt = '0;
              end
            end
          end
          rhp_pkg::PH_BITMAP: begin
            // offset 4 is word-aligned, so the byte lane is o[1:0]
            acc_nxt = acc_r | ({56'd0, b} << {o[1:0], 3'b000});
            if (o[1:0] == 2'd3) begin
              acc_nxt = '0;
              if (o == 16'd7) pres_nxt = word;
              if (word[31]) begin
                if ({1'b0, o} + 17'd5 > {1'b0, hl_r}) begin
                  res1_v = 1'b1;
                  res1 = '{rhp_pkg::KIND_END, 64'd0, rhp_pkg::ERR_OVERRUN, 1'b1};
                  phase_nxt = rhp_pkg::PH_DONE;
                end
              end else begin
                phase_nxt = rhp_pkg::PH_FIELDS;
                run_after = 1'b1;
              end
            end
          end
          rhp_pkg::PH_FIELDS: begin
            if (cur_r != rhp_pkg::NoField) begin
              acc_new = acc_r;
              if (fbl_r == 4'd0 && o == fs_r) begin
                fbl_eff = size;
                acc_new = '0;
              end
              if (fbl_eff != 4'd0) begin
                kdiff = size - fbl_eff;
                acc_new = acc_new | ({56'd0, b} << {kdiff[2:0], 3'b000});
                acc_nxt = acc_new;
                fbl_nxt = fbl_eff - 4'd1;
                w = acc_new[15:0];
                if (fbl_eff == 4'd1) begin
                  run_after = 1'b1;
                  case (cur_r)
                    5'd0: begin
                      res0_v = 1'b1;
                      res0 = '{rhp_pkg::KIND_TSFT, acc_new, rhp_pkg::ERR_OK, 1'b0};
                    end
                    5'd1: begin
                      if (acc_new[4]) fcs_nxt = 1'b1;
                      cfb_nxt = cfb_r | (acc_new[1] ? 8'h40 : 8'h80);
                      res0_v = 1'b1;
                      res0 = '{rhp_pkg::KIND_RXFLAGS, {62'd0, acc_new[1], acc_new[6]},
                               rhp_pkg::ERR_OK, 1'b0};
                    end
                    5'd2: begin
                      res0_v = 1'b1;
                      res0 = '{rhp_pkg::KIND_RATE,
                               {47'd0, 17'(acc_new[7:0]) * 17'd500},
                               rhp_pkg::ERR_OK, 1'b0};
                    end
                    5'd3: begin
                      if (part_r == 4'd0) begin
                        res0_v = 1'b1;
                        res0 = '{rhp_pkg::KIND_FREQ, {48'd0, w}, rhp_pkg::ERR_OK, 1'b0};
                      end else if (w[4] || w[13]) begin
                        // turbo channel: error replaces the chanflags word
                        run_after = 1'b0;
                        res1_v = 1'b1;
                        res1 = '{rhp_pkg::KIND_END, 64'd0, rhp_pkg::ERR_TURBO, 1'b1};
                        phase_nxt = rhp_pkg::PH_DONE;
                      end else begin
                        m[0] = w[5];
                        m[1] = w[6];
                        m[2] = w[11];
                        m[3] = w[10];
                        m[5] = w[15];
                        m[4] = w[14] && !w[15];
                        cfb_nxt = cfb_r | m;
                        res0_v = 1'b1;
                        res0 = '{rhp_pkg::KIND_CHANFLAGS, {56'd0, cfb_nxt},
                                 rhp_pkg::ERR_OK, 1'b0};
                      end
                    end
                    5'd5: begin
                      res0_v = 1'b1;
                      res0 = '{rhp_pkg::KIND_SIGNAL, {56'd0, acc_new[7:0]},
                               rhp_pkg::ERR_OK, 1'b0};
                    end
                    5'd15: begin
                      res0_v = 1'b1;
                      res0 = '{rhp_pkg::KIND_TXFAIL, {63'd0, w[0]}, rhp_pkg::ERR_OK, 1'b0};
                    end
                    5'd16: begin
                      res0_v = 1'b1;
                      res0 = '{rhp_pkg::KIND_RTS, {56'd0, acc_new[7:0]},
                               rhp_pkg::ERR_OK, 1'b0};
                    end
                    5'd17: begin
                      res0_v = 1'b1;
                      res0 = '{rhp_pkg::KIND_DATARETRY, {56'd0, acc_new[7:0]},
                               rhp_pkg::ERR_OK, 1'b0};
                    end
                    5'd29: begin
                      res0_v = 1'b1;
                      res0 = '{rhp_pkg::KIND_PKTTIME, {32'd0, acc_new[31:0]},
                               rhp_pkg::ERR_OK, 1'b0};
                    end
                    default: ;
                  endcase
                end
              end
            end else if ({1'b0, o} + 17'd1 == {1'b0, hl_r}) begin
              run_after = 1'b1;
            end
          end
          default: ;
        endcase

        if (run_after) begin
          if (sk.short_read) begin
            res1_v = 1'b1;
            res1 = '{rhp_pkg::KIND_END, 64'd0, rhp_pkg::ERR_SHORT_READ, 1'b1};
            phase_nxt = rhp_pkg::PH_DONE;
          end else begin
            cur_nxt  = sk.fbit;
            part_nxt = (sk.fbit == sk_cur) ? sk_part : 4'd0;
            fs_nxt   = (sk.fbit != rhp_pkg::NoField) ? sk.start : o1;
            if (sk.fbit == rhp_pkg::NoField && ({1'b0, o} + 17'd1 == {1'b0, hl_r})) begin
              pay = {2'b00, fl_r} - {2'b00, hl_r} - (fcs_nxt ? 18'd4 : 18'd0);
              res1_v = 1'b1;
              res1 = '{rhp_pkg::KIND_END, {48'd0, pay[17] ? 16'd0 : pay[15:0]},
                       rhp_pkg::ERR_OK, 1'b1};
              phase_nxt = rhp_pkg::PH_DONE;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rhp_pkg::PH_IDLE;
      off_r <= '0; hl_r <= '0; fl_r <= '0; fs_r <= '0; pres_r <= '0;
      cur_r <= '0; part_r <= '0; fbl_r <= '0; acc_r <= '0; cfb_r <= '0;
      fcs_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      off_r <= off_nxt; hl_r <= hl_nxt; fl_r <= fl_nxt; fs_r <= fs_nxt;
      pres_r <= pres_nxt; cur_r <= cur_nxt; part_r <= part_nxt; fbl_r <= fbl_nxt;
      acc_r <= acc_nxt; cfb_r <= cfb_nxt; fcs_r <= fcs_nxt;
    end
  end

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (res1_v && res1.is_last) |=> (phase_r == rhp_pkg::PH_DONE))
    else $error("closing word without done phase");
  a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    res0_v |-> (!res0.is_last && res0.error_code == rhp_pkg::ERR_OK))
    else $error("field word marked last");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == rhp_pkg::PH_DONE && !(accept && in_data.start_of_frame))
      |-> (!res0_v && !res1_v))
    else $error("result after frame closed");

endmodule
